>>> rtl/sta_pkg.sv
package sta_pkg;

  localparam int TIME_W    = 31;
  localparam int STAMP_W   = 17;
  localparam int SLOT_IN_W = 3;
  localparam int COUNT_W   = 4;

  // Stamp is attach time modulo STAMP_MOD. STAMP_MOD is 3125 << MOD_SHIFT, so
  // the quotient is ((time >> MOD_SHIFT) * RECIP) >> RECIP_SHIFT, exact for
  // every 31-bit time; the remainder follows by multiplying back and subtracting.
  localparam int unsigned STAMP_MOD   = 100000;
  localparam int          MOD_SHIFT   = 5;
  localparam int          RED_W       = TIME_W - MOD_SHIFT;
  localparam int          RECIP_W     = 27;
  localparam int          RECIP_SHIFT = 38;
  localparam int          PROD_W      = RED_W + RECIP_W;
  localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(87960931);

  localparam logic [TIME_W-1:0] TTL_RESET = TIME_W'(10000);

  typedef enum logic [1:0] {
    OP_ATTACH    = 2'd0,
    OP_HEARTBEAT = 2'd1,
    OP_DETACH    = 2'd2,
    OP_REAP      = 2'd3
  } op_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MOD   = 7'b0000010,
    S_FREE  = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_REAP  = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

endpackage

>>> rtl/sta_ram.sv
module sta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sta_mod.sv
module sta_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sta_pkg::TIME_W-1:0]    dividend,
  output logic                          done,
  output logic [sta_pkg::STAMP_W-1:0]   rem
);

  import sta_pkg::*;

  logic [TIME_W-1:0]  num;
  logic [PROD_W-1:0]  prod;
  logic [QUOT_W-1:0]  quot;
  logic [TIME_W-1:0]  back;
  logic [STAMP_W-1:0] rem_r;
  logic               num_vld;
  logic               quot_vld;

  // x / 100000 = (x >> 5) / 3125, taken as a reciprocal multiply
  assign prod = PROD_W'(num[TIME_W-1:MOD_SHIFT]) * PROD_W'(RECIP);
  assign back = TIME_W'(quot) * TIME_W'(STAMP_MOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vld  <= 1'b0;
      quot_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      num_vld  <= start;
      quot_vld <= num_vld;
      done     <= quot_vld;
    end
  end

  // hold the time, then the quotient, then the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
    end
    if (num_vld) begin
      quot <= prod[PROD_W-1:RECIP_SHIFT];
    end
    if (quot_vld) begin
      rem_r <= STAMP_W'(num - back);
    end
  end

  assign rem = rem_r;

endmodule

>>> rtl/session_table_with_aging_core.sv
// Session table with timeout aging. SLOTS session slots, each holding a used
// bit (flip-flops, cleared by reset) and a last-seen time and stamp kept in one
// synchronous RAM word per slot; the RAM needs no clearing pass, since an entry
// is only relied on once attach has written it. One item is worked at a time:
// heartbeat and detach do one RAM read of the named slot, then compare and
// (heartbeat only) write back; reap does one RAM read per slot to age it
// against ttl; attach waits on a three-stage reduction of the time modulo
// 100000 (reciprocal multiply, then multiply back and subtract) followed by
// a scan of the used bits for the lowest free slot. A finished result word
// sits in the output register, so the next item is taken while it waits. ttl
// is written over the cfg channel, which is always ready; write it only while
// the block is idle.
module session_table_with_aging_core #(
  parameter int SLOTS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sta_pkg::TIME_W-1:0]     cfg_data,
  // request words
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     op,
  input  logic [sta_pkg::TIME_W-1:0]     now_time,
  input  logic [sta_pkg::SLOT_IN_W-1:0]  session_slot,
  input  logic [sta_pkg::STAMP_W-1:0]    session_stamp,
  // result words
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           status,
  output logic [sta_pkg::SLOT_IN_W-1:0]  slot_out,
  output logic [sta_pkg::STAMP_W-1:0]    stamp_out,
  output logic [sta_pkg::COUNT_W-1:0]    reaped,
  output logic [sta_pkg::COUNT_W-1:0]    active_sessions,
  output logic [sta_pkg::SLOT_IN_W-1:0]  recent_slot,
  output logic                           recent_valid
);

  import sta_pkg::*;

  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW     = $clog2(SLOTS + 1);
  localparam int WORD_W = TIME_W + STAMP_W;

  state_t state;

  logic [TIME_W-1:0]    ttl;
  logic [SLOTS-1:0]     used;
  logic [CW-1:0]        active;
  logic [SW-1:0]        recent_idx;
  logic                 recent_flag;

  // held request word
  op_t                  op_q;
  logic [TIME_W-1:0]    now_q;
  logic [SLOT_IN_W-1:0] slot_q;
  logic [STAMP_W-1:0]   stamp_q;

  // scan state
  logic [CW-1:0]        cnt;
  logic [SW-1:0]        rd_idx;
  logic                 rd_vld;
  logic [CW-1:0]        reap_cnt;

  // staged result fields
  logic                 res_status;
  logic [SLOT_IN_W-1:0] res_slot;
  logic [STAMP_W-1:0]   res_stamp;

  logic                 ram_we;
  logic [SW-1:0]        ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [SW-1:0]        ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;
  logic [TIME_W-1:0]    rd_time;
  logic [STAMP_W-1:0]   rd_stamp;

  logic                 mod_start;
  logic                 mod_done;
  logic [STAMP_W-1:0]   mod_rem;

  logic                 accept;
  logic                 slot_in_range;
  logic [SW-1:0]        slot_idx;
  logic                 scan_end;
  logic                 free_hit;
  logic                 match;
  logic                 hb_hit;
  logic                 dt_hit;
  logic signed [TIME_W:0] age;
  logic                 reap_hit;
  logic                 out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;

  assign slot_in_range = (int'(session_slot) < SLOTS);
  assign slot_idx      = SW'(slot_q);
  assign rd_time       = ram_rdata[WORD_W-1:STAMP_W];
  assign rd_stamp      = ram_rdata[STAMP_W-1:0];
  assign scan_end      = (cnt == CW'(SLOTS));

  // lowest free slot, one used bit a cycle
  assign free_hit = (state == S_FREE) && !scan_end && !used[cnt[SW-1:0]];

  assign match  = used[slot_idx] && (rd_stamp == stamp_q);
  assign hb_hit = (state == S_CHECK) && match && (op_q == OP_HEARTBEAT);
  assign dt_hit = (state == S_CHECK) && match && (op_q == OP_DETACH);

  // signed age: a time earlier than last-seen never expires
  assign age      = $signed({1'b0, now_q}) - $signed({1'b0, rd_time});
  assign reap_hit = (state == S_REAP) && rd_vld && used[rd_idx] &&
                    (age > $signed({1'b0, ttl}));

  assign out_load = (state == S_FIN) && (!out_valid || out_ready);

  // read the named slot while idle so its word is ready in CHECK
  assign ram_raddr = (state == S_REAP) ? cnt[SW-1:0] : SW'(session_slot);
  assign ram_we    = free_hit || hb_hit;
  assign ram_waddr = free_hit ? cnt[SW-1:0] : slot_idx;
  assign ram_wdata = free_hit ? {now_q, mod_rem} : {now_q, rd_stamp};

  assign mod_start = accept && (op_t'(op) == OP_ATTACH);

  sta_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sta_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (now_time),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ttl         <= TTL_RESET;
      used        <= '0;
      active      <= '0;
      recent_idx  <= '0;
      recent_flag <= 1'b0;
      rd_vld      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ttl <= cfg_data;
      end

      // table updates; at most one of these fires in a cycle
      if (free_hit) begin
        used[cnt[SW-1:0]] <= 1'b1;
        active            <= active + 1'b1;
        recent_idx        <= cnt[SW-1:0];
        recent_flag       <= 1'b1;
      end
      if (hb_hit) begin
        recent_idx  <= slot_idx;
        recent_flag <= 1'b1;
      end
      if (dt_hit) begin
        used[slot_idx] <= 1'b0;
        active         <= active - 1'b1;
      end
      if (reap_hit) begin
        used[rd_idx] <= 1'b0;
        active       <= active - 1'b1;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q       <= op_t'(op);
            now_q      <= now_time;
            slot_q     <= session_slot;
            stamp_q    <= session_stamp;
            cnt        <= '0;
            reap_cnt   <= '0;
            rd_vld     <= 1'b0;
            // a slot beyond the table fails at once
            res_status <= ((op_t'(op) == OP_HEARTBEAT) || (op_t'(op) == OP_DETACH)) &&
                          !slot_in_range;
            res_slot   <= '0;
            res_stamp  <= '0;
            unique case (op_t'(op))
              OP_ATTACH: state <= S_MOD;
              OP_HEARTBEAT, OP_DETACH: begin
                if (slot_in_range) begin
                  state <= S_CHECK;
                end else begin
                  state <= S_FIN;
                end
              end
              OP_REAP: state <= S_REAP;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MOD: begin
          // wait for the stamp
          if (mod_done) begin
            state <= S_FREE;
          end
        end
        S_FREE: begin
          if (scan_end) begin
            res_status <= 1'b1;
            state      <= S_FIN;
          end else if (free_hit) begin
            res_slot  <= SLOT_IN_W'(cnt[SW-1:0]);
            res_stamp <= mod_rem;
            state     <= S_FIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_CHECK: begin
          if (match) begin
            res_slot <= slot_q;
          end else begin
            res_status <= 1'b1;
          end
          state <= S_FIN;
        end
        S_REAP: begin
          // issue one read a cycle, age the slot read last cycle
          if (!scan_end) begin
            rd_idx <= cnt[SW-1:0];
            rd_vld <= 1'b1;
            cnt    <= cnt + 1'b1;
          end else begin
            rd_vld <= 1'b0;
          end
          if (reap_hit) begin
            reap_cnt <= reap_cnt + 1'b1;
          end
          if (scan_end && !rd_vld) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result word payload; takes counters as they stand after the step
  always_ff @(posedge clk) begin
    if (out_load) begin
      status          <= res_status;
      slot_out        <= res_slot;
      stamp_out       <= res_stamp;
      reaped          <= COUNT_W'(reap_cnt);
      active_sessions <= COUNT_W'(active);
      recent_slot     <= SLOT_IN_W'(recent_idx);
      recent_valid    <= recent_flag;
    end
  end

`ifndef NO_ASSERTIONS
  a_active_count: assert property (@(posedge clk) disable iff (rst)
    int'(active) == $countones(used))
    else $error("active count out of step with used bits");

  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (slot_out == '0) && (stamp_out == '0) && (reaped == '0))
    else $error("failed result carries non-zero fields");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted word left the block idle");

  a_recent_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(recent_flag))
    else $error("recent flag cleared outside reset");

  a_single_update: assert property (@(posedge clk) disable iff (rst)
    $onehot0({free_hit, hb_hit, dt_hit, reap_hit}))
    else $error("two table updates in one cycle");
`endif

endmodule
